>>> rtl/sss_pkg.sv
// shared types, constants and helpers for the stepper sweep sequencer
// no dependencies; imported by every module of the block
package sss_pkg;

  // stream payload widths, fields packed from bit 0 and padded to bytes
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_SEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_DELAY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_TOTAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BLINK         = 3'd5;

  // register reset values
  localparam logic       RST_DIRECTION     = 1'b1;
  localparam logic [9:0] RST_STEPS_PER_SEG = 10'd64;
  localparam logic [7:0] RST_PHASE_DELAY   = 8'd5;
  localparam logic [3:0] RST_SEGMENT_TOTAL = 4'd8;
  localparam logic [7:0] RST_DEBOUNCE      = 8'd10;
  localparam logic [7:0] RST_BLINK         = 8'd20;

  // last phase of a full step
  localparam logic [1:0] LAST_PHASE = 2'd3;

  typedef struct packed {
    logic       direction;
    logic [9:0] steps_per_segment;
    logic [7:0] phase_delay;
    logic [3:0] segment_total;
    logic [7:0] debounce_ticks;
    logic [7:0] blink_ticks;
  } cfg_t;

  typedef struct packed {
    logic       busy_res;
    logic       led_on;
    logic [3:0] coil_pattern;
  } res_t;

  typedef enum logic [2:0] {
    MODE_IDLE         = 3'd0,
    MODE_DEBOUNCE     = 3'd1,
    MODE_WAIT_RELEASE = 3'd2,
    MODE_RUN          = 3'd3,
    MODE_BLINK        = 3'd4
  } mode_t;

  // coil pattern for a phase; counter-clockwise walks the table backwards
  function automatic logic [3:0] coil_for(input logic dir, input logic [1:0] idx);
    logic [1:0] k;
    logic [3:0] pat;
    k = dir ? idx : ~idx;
    case (k)
      2'd0:    pat = 4'b1001;
      2'd1:    pat = 4'b0011;
      2'd2:    pat = 4'b0110;
      default: pat = 4'b1100;
    endcase
    return pat;
  endfunction

endpackage

>>> rtl/stepper_sweep_sequencer.sv
// stepper sweep sequencer: one result per tick, one tick accepted per cycle
// latency: the result of a tick sits in the output register from the cycle after its transfer
// throughput: one tick per cycle, held off only while a result waits and m_tready is low
// reset (rst, synchronous): sequencer idle, coils and led off, registers to their defaults,
// output register empty
// depends on sss_pkg, sss_cfg and sss_ctrl
module stepper_sweep_sequencer import sss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // [0] button_level, rest zero
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [3:0] coil_pattern, [4] led_on, [5] busy_res
);

  cfg_t cfg;
  res_t res_next;
  res_t res;
  logic in_xfer;

  assign s_tready = !rst && (!m_tvalid || m_tready);
  assign in_xfer  = s_tvalid && s_tready;

  sss_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  sss_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .step_en      (in_xfer),
    .button_level (s_tdata[0]),
    .cfg          (cfg),
    .res_next     (res_next)
  );

  // output register, refilled on a transfer in, emptied on a transfer out
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_xfer) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) res <= res_next;
  end

  assign m_tdata = {{(OUT_DATA_W - $bits(res_t)){1'b0}}, res};

endmodule

>>> rtl/sss_cfg.sv
// configuration register bank of the stepper sweep sequencer
// depends on sss_pkg for register indexes, reset values and cfg_t
module sss_cfg import sss_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.direction         <= RST_DIRECTION;
      cfg.steps_per_segment <= RST_STEPS_PER_SEG;
      cfg.phase_delay       <= RST_PHASE_DELAY;
      cfg.segment_total     <= RST_SEGMENT_TOTAL;
      cfg.debounce_ticks    <= RST_DEBOUNCE;
      cfg.blink_ticks       <= RST_BLINK;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_DIRECTION:     cfg.direction         <= cfg_wdata[0];
        CFG_STEPS_PER_SEG: cfg.steps_per_segment <= cfg_wdata[9:0];
        CFG_PHASE_DELAY:   cfg.phase_delay       <= cfg_wdata[7:0];
        CFG_SEGMENT_TOTAL: cfg.segment_total     <= cfg_wdata[3:0];
        CFG_DEBOUNCE:      cfg.debounce_ticks    <= cfg_wdata[7:0];
        CFG_BLINK:         cfg.blink_ticks       <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/sss_ctrl.sv
// sequencer state machine: mode, phase, tick, step and segment counters
// depends on sss_pkg; advances one tick per step_en, gives the post-tick result
module sss_ctrl import sss_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step_en,
  input  logic button_level,
  input  cfg_t cfg,
  output res_t res_next
);

  mode_t      mode, mode_next;
  logic [1:0] phase_index, phase_index_next;
  logic [7:0] tick_count, tick_count_next;
  logic [9:0] step_count, step_count_next;
  logic [3:0] segment_count, segment_count_next;
  logic [3:0] coil_hold, coil_hold_next;
  logic       led_hold, led_hold_next;

  logic [9:0] steps_min1;
  logic [3:0] segs_min1;
  logic [7:0] phase_reload, blink_reload, tick_dec;
  logic [9:0] step_inc;
  logic [3:0] seg_inc;
  logic       tick_zero, debounce_done, step_done, sweep_done, last_phase;

  // zero settings count as one
  assign steps_min1   = (cfg.steps_per_segment == 10'd0) ? 10'd1 : cfg.steps_per_segment;
  assign segs_min1    = (cfg.segment_total == 4'd0) ? 4'd1 : cfg.segment_total;
  assign phase_reload = (cfg.phase_delay == 8'd0) ? 8'd0 : cfg.phase_delay - 8'd1;
  assign blink_reload = (cfg.blink_ticks == 8'd0) ? 8'd0 : cfg.blink_ticks - 8'd1;

  assign tick_zero     = (tick_count == 8'd0);
  assign tick_dec      = tick_count - 8'd1;
  assign debounce_done = tick_zero || (tick_dec == 8'd0);
  assign step_inc      = step_count + 10'd1;
  assign seg_inc       = segment_count + 4'd1;
  assign step_done     = (step_inc >= steps_min1);
  assign sweep_done    = (seg_inc >= segs_min1);
  assign last_phase    = (phase_index >= LAST_PHASE);

  // next mode
  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_DEBOUNCE: begin
        if (debounce_done) mode_next = MODE_WAIT_RELEASE;
      end
      MODE_WAIT_RELEASE: begin
        if (!button_level) mode_next = MODE_RUN;
      end
      MODE_RUN: begin
        if (tick_zero && last_phase && step_done) mode_next = MODE_BLINK;
      end
      MODE_BLINK: begin
        if (tick_zero) mode_next = sweep_done ? MODE_IDLE : MODE_RUN;
      end
      default: begin
        mode_next = MODE_IDLE;
        if (button_level) begin
          mode_next = (cfg.debounce_ticks == 8'd0) ? MODE_WAIT_RELEASE : MODE_DEBOUNCE;
        end
      end
    endcase
  end

  // counters and held outputs
  always_comb begin
    phase_index_next   = phase_index;
    tick_count_next    = tick_count;
    step_count_next    = step_count;
    segment_count_next = segment_count;
    coil_hold_next     = coil_hold;
    led_hold_next      = led_hold;
    case (mode)
      MODE_DEBOUNCE: begin
        if (!tick_zero) tick_count_next = tick_dec;
      end
      MODE_WAIT_RELEASE: begin
        if (!button_level) begin
          segment_count_next = 4'd0;
          phase_index_next   = 2'd0;
          step_count_next    = 10'd0;
          coil_hold_next     = coil_for(cfg.direction, 2'd0);
          tick_count_next    = phase_reload;
        end
      end
      MODE_RUN: begin
        if (!tick_zero) begin
          tick_count_next = tick_dec;
        end else if (last_phase) begin
          step_count_next = step_inc;
          if (step_done) begin
            led_hold_next   = 1'b1;
            tick_count_next = blink_reload;
          end else begin
            phase_index_next = 2'd0;
            coil_hold_next   = coil_for(cfg.direction, 2'd0);
            tick_count_next  = phase_reload;
          end
        end else begin
          phase_index_next = phase_index + 2'd1;
          coil_hold_next   = coil_for(cfg.direction, phase_index + 2'd1);
          tick_count_next  = phase_reload;
        end
      end
      MODE_BLINK: begin
        if (!tick_zero) begin
          tick_count_next = tick_dec;
        end else begin
          led_hold_next      = 1'b0;
          segment_count_next = seg_inc;
          if (sweep_done) begin
            tick_count_next = 8'd0;
          end else begin
            phase_index_next = 2'd0;
            step_count_next  = 10'd0;
            coil_hold_next   = coil_for(cfg.direction, 2'd0);
            tick_count_next  = phase_reload;
          end
        end
      end
      default: begin
        if (button_level && (cfg.debounce_ticks != 8'd0)) begin
          tick_count_next = cfg.debounce_ticks;
        end
      end
    endcase
  end

  assign res_next.coil_pattern = coil_hold_next;
  assign res_next.led_on       = led_hold_next;
  assign res_next.busy_res     = (mode_next != MODE_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_IDLE;
      phase_index   <= 2'd0;
      tick_count    <= 8'd0;
      step_count    <= 10'd0;
      segment_count <= 4'd0;
      coil_hold     <= 4'd0;
      led_hold      <= 1'b0;
    end else if (step_en) begin
      mode          <= mode_next;
      phase_index   <= phase_index_next;
      tick_count    <= tick_count_next;
      step_count    <= step_count_next;
      segment_count <= segment_count_next;
      coil_hold     <= coil_hold_next;
      led_hold      <= led_hold_next;
    end
  end

endmodule

>>> rtl/sss_checker.sv
// port-level checks for the stepper sweep sequencer, bound to the top level
// depends on sss_pkg for the stream widths
module sss_checker import sss_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // input side opens whenever the output register is free or draining
  assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("s_tready does not follow output register");

  // every input transfer gives a result next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("input transfer gave no result");

  // output register empty after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result present after reset");

  // led is never lit while the sequencer is idle
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[5] |-> !m_tdata[4])
    else $error("led lit while idle");

endmodule

bind stepper_sweep_sequencer sss_checker u_sss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

>>> verif/tb_stepper_sweep_sequencer.sv
`timescale 1ns / 100ps
// self-checking bench for the stepper sweep sequencer: directed table, then random sweeps
// depends on sss_pkg and the stepper_sweep_sequencer rtl
module tb_stepper_sweep_sequencer;
  import sss_pkg::*;

  localparam int unsigned RUN_LIMIT_NS = 20_000_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam logic [3:0] CW_PATTERN [4] = '{4'b1001, 4'b0011, 4'b0110, 4'b1100};

  typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic                  btn;
    logic                  typed;
    res_t                  res;
  } dir_row_t;

  localparam int DIR_ROWS = 33;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{ROW_CFG,  CFG_DIRECTION,     10'd1, 1'b0, 1'b0, '0},
    '{ROW_CFG,  CFG_STEPS_PER_SEG, 10'd1, 1'b0, 1'b0, '0},
    '{ROW_CFG,  CFG_PHASE_DELAY,   10'd1, 1'b0, 1'b0, '0},
    '{ROW_CFG,  CFG_SEGMENT_TOTAL, 10'd1, 1'b0, 1'b0, '0},
    '{ROW_CFG,  CFG_DEBOUNCE,      10'd0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  CFG_BLINK,         10'd1, 1'b0, 1'b0, '0},
    // idle, then a press with no debounce wait, then one single-step segment
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b1, '{1'b0, 1'b0, 4'b0000}},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b1, 1'b1, '{1'b1, 1'b0, 4'b0000}},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b1, 1'b1, '{1'b1, 1'b0, 4'b0000}},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b1, '{1'b1, 1'b0, 4'b1001}},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b1, '{1'b1, 1'b0, 4'b0011}},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b1, 1'b1, '{1'b1, 1'b0, 4'b0110}},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b1, '{1'b1, 1'b0, 4'b1100}},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b1, '{1'b1, 1'b1, 4'b1100}},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b1, '{1'b0, 1'b0, 4'b1100}},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b1, '{1'b0, 1'b0, 4'b1100}},
    // counter-clockwise with zero settings taken as one, short debounce
    '{ROW_CFG,  CFG_DIRECTION,     10'd0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  CFG_STEPS_PER_SEG, 10'd0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  CFG_PHASE_DELAY,   10'd0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  CFG_SEGMENT_TOTAL, 10'd0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  CFG_BLINK,         10'd0, 1'b0, 1'b0, '0},
    '{ROW_CFG,  CFG_DEBOUNCE,      10'd2, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b1, 1'b0, '0},
    '{ROW_TICK, CFG_DIRECTION,     10'd0, 1'b0, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wen = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  stepper_sweep_sequencer uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // [0] button_level, rest zero
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)    // [3:0] coil_pattern, [4] led_on, [5] busy_res
  );

  always #6 clk = ~clk;

  // sequencer shadow
  cfg_t       settings;
  mode_t      seq_mode;
  logic [1:0] phase_idx;
  logic [7:0] hold_ticks;
  logic [9:0] steps_done;
  logic [3:0] segs_done;
  logic [3:0] coil_now;
  logic       led_now;

  res_t due_outputs [$];
  int   mismatches = 0;
  int   ticks_sent = 0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  logic hold_trigger = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  function automatic logic [9:0] at_least_one(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic void show_pattern();
    coil_now   = settings.direction ? CW_PATTERN[phase_idx] : CW_PATTERN[2'd3 - phase_idx];
    hold_ticks = 8'(at_least_one(10'(settings.phase_delay)) - 10'd1);
  endfunction

  function automatic void start_segment();
    phase_idx  = 2'd0;
    steps_done = 10'd0;
    seq_mode   = MODE_RUN;
    show_pattern();
  endfunction

  // advance the shadow by one tick and return the outputs after it
  function automatic res_t step_sequencer(input logic btn);
    case (seq_mode)
      MODE_DEBOUNCE: begin
        if (hold_ticks != 8'd0) hold_ticks = hold_ticks - 8'd1;
        if (hold_ticks == 8'd0) seq_mode = MODE_WAIT_RELEASE;
      end
      MODE_WAIT_RELEASE: begin
        if (!btn) begin
          segs_done = 4'd0;
          start_segment();
        end
      end
      MODE_RUN: begin
        if (hold_ticks != 8'd0) begin
          hold_ticks = hold_ticks - 8'd1;
        end else if (phase_idx == LAST_PHASE) begin
          steps_done = steps_done + 10'd1;
          if (steps_done >= at_least_one(settings.steps_per_segment)) begin
            seq_mode   = MODE_BLINK;
            led_now    = 1'b1;
            hold_ticks = 8'(at_least_one(10'(settings.blink_ticks)) - 10'd1);
          end else begin
            phase_idx = 2'd0;
            show_pattern();
          end
        end else begin
          phase_idx = phase_idx + 2'd1;
          show_pattern();
        end
      end
      MODE_BLINK: begin
        if (hold_ticks != 8'd0) begin
          hold_ticks = hold_ticks - 8'd1;
        end else begin
          led_now   = 1'b0;
          segs_done = segs_done + 4'd1;
          if (10'(segs_done) >= at_least_one(10'(settings.segment_total))) begin
            seq_mode   = MODE_IDLE;
            hold_ticks = 8'd0;
          end else begin
            start_segment();
          end
        end
      end
      default: begin
        seq_mode = MODE_IDLE;
        if (btn) begin
          if (settings.debounce_ticks == 8'd0) begin
            seq_mode = MODE_WAIT_RELEASE;
          end else begin
            seq_mode   = MODE_DEBOUNCE;
            hold_ticks = settings.debounce_ticks;
          end
        end
      end
    endcase
    return '{busy_res: (seq_mode != MODE_IDLE), led_on: led_now, coil_pattern: coil_now};
  endfunction

  task automatic send_tick(input logic btn, input logic typed = 1'b0, input res_t typed_res = '0);
    res_t predicted;
    cfg_wen <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W-1){1'b0}}, btn};
    do @(posedge clk); while (!s_tready);
    predicted = step_sequencer(btn);
    due_outputs.push_back(typed ? typed_res : predicted);
    ticks_sent++;
  endtask

  task automatic drain_outputs();
    s_tvalid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
  endtask

  // write enable is left high; the next send_tick lowers it before it offers its tick
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_DIRECTION:     settings.direction         = val[0];
      CFG_STEPS_PER_SEG: settings.steps_per_segment = val;
      CFG_PHASE_DELAY:   settings.phase_delay       = val[7:0];
      CFG_SEGMENT_TOTAL: settings.segment_total     = val[3:0];
      CFG_DEBOUNCE:      settings.debounce_ticks    = val[7:0];
      CFG_BLINK:         settings.blink_ticks       = val[7:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input cfg_t c);
    drain_outputs();
    cfg_write(CFG_DIRECTION, 10'(c.direction));
    cfg_write(CFG_STEPS_PER_SEG, c.steps_per_segment);
    cfg_write(CFG_PHASE_DELAY, 10'(c.phase_delay));
    cfg_write(CFG_SEGMENT_TOTAL, 10'(c.segment_total));
    cfg_write(CFG_DEBOUNCE, 10'(c.debounce_ticks));
    cfg_write(CFG_BLINK, 10'(c.blink_ticks));
  endtask

  // mostly press, release and ride out the sweep; some runs of random button noise
  task automatic run_sweeps(input int budget);
    int stop_at;
    int press_len;
    stop_at = ticks_sent + budget;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(1)));
      end else begin
        repeat ($urandom_range(0, 3)) send_tick(1'b0);
        press_len = $urandom_range(1, int'(settings.debounce_ticks) + 4);
        repeat (press_len) send_tick(1'b1);
        while (seq_mode != MODE_IDLE && ticks_sent < stop_at)
          send_tick($urandom_range(99) < 10);
      end
    end
  endtask

  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_OFF_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_outputs
    res_t got;
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = res_t'(m_tdata[$bits(res_t)-1:0]);
      if (due_outputs.size() == 0) begin
        $display("%0t: unexpected output transfer, expected none, actual %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = due_outputs.pop_front();
        if (got.coil_pattern !== want.coil_pattern) begin
          $display("%0t: coil_pattern expected %b actual %b",
                   $time, want.coil_pattern, got.coil_pattern);
          mismatches++;
        end
        if (got.led_on !== want.led_on) begin
          $display("%0t: led_on expected %b actual %b", $time, want.led_on, got.led_on);
          mismatches++;
        end
        if (got.busy_res !== want.busy_res) begin
          $display("%0t: busy_res expected %b actual %b", $time, want.busy_res, got.busy_res);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    settings = '{direction: RST_DIRECTION, steps_per_segment: RST_STEPS_PER_SEG,
                 phase_delay: RST_PHASE_DELAY, segment_total: RST_SEGMENT_TOTAL,
                 debounce_ticks: RST_DEBOUNCE, blink_ticks: RST_BLINK};
    seq_mode   = MODE_IDLE;
    phase_idx  = 2'd0;
    hold_ticks = 8'd0;
    steps_done = 10'd0;
    segs_done  = 4'd0;
    coil_now   = 4'd0;
    led_now    = 1'b0;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (DIR_TABLE[r].kind == ROW_CFG) begin
        drain_outputs();
        cfg_write(DIR_TABLE[r].idx, DIR_TABLE[r].val);
      end else begin
        send_tick(DIR_TABLE[r].btn, DIR_TABLE[r].typed, DIR_TABLE[r].res);
      end
    end

    // small random settings; phases often end mid-sweep so writes land while running
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 78; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 78; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      apply_settings('{direction: 1'($urandom_range(1)),
                       steps_per_segment: 10'($urandom_range(0, 4)),
                       phase_delay: 8'($urandom_range(0, 3)),
                       segment_total: 4'($urandom_range(0, 3)),
                       debounce_ticks: 8'($urandom_range(0, 5)),
                       blink_ticks: 8'($urandom_range(0, 3))});
      run_sweeps(50);
    end

    // output held off for a long stretch while ticks keep coming, so the input stalls
    send_idle_pct  = 0;
    recv_stall_pct = 28;
    hold_trigger <= ~hold_trigger;
    run_sweeps(100);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    apply_settings('{direction: 1'b1, steps_per_segment: 10'd1023, phase_delay: 8'd1,
                     segment_total: 4'd1, debounce_ticks: 8'd0, blink_ticks: 8'd1});
    run_sweeps(150);

    send_idle_pct  = 28;
    recv_stall_pct = 28;
    apply_settings('{direction: 1'b0, steps_per_segment: 10'd1, phase_delay: 8'd255,
                     segment_total: 4'd1, debounce_ticks: 8'd255, blink_ticks: 8'd255});
    run_sweeps(200);

    apply_settings('{direction: 1'b1, steps_per_segment: 10'd2, phase_delay: 8'd1,
                     segment_total: 4'd15, debounce_ticks: 8'd3, blink_ticks: 8'd1});
    run_sweeps(200);

    recv_stall_pct = 0;
    drain_outputs();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && due_outputs.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
